>>> rtl/trnh_pkg.sv
// Shared types, constants and port-code helpers for the two-tree next-hop router.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package trnh_pkg;

  // Field widths fixed by the id format
  localparam int BIN_W      = 30;                // binary id width
  localparam int BCD_DIGITS = 10;                // decimal digits a 30-bit value can need
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int CNT_W      = 4;                 // digit positions and lengths, 0 to 10
  localparam int BIT_CNT_W  = $clog2(BIN_W);
  localparam int CFG_IDX_W  = 2;
  localparam int PORT_W     = 3;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [PORT_W-1:0]  port_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Output port codes
  localparam port_t PORT_LOCAL = 3'd0;
  localparam port_t PORT_NORTH = 3'd1;
  localparam port_t PORT_SOUTH = 3'd2;
  localparam port_t PORT_EAST  = 3'd3;
  localparam port_t PORT_WEST  = 3'd4;
  localparam port_t PORT_NONE  = 3'd5;

  // Configuration register indexes
  localparam cfg_idx_t REG_TILE_X = 2'd0;
  localparam cfg_idx_t REG_TILE_Y = 2'd1;

  // Converter commands
  typedef struct packed {
    logic load;
    logic bit_step;
    logic digit_step;
  } conv_ctl_t;

  // Summary of one tree after the low-to-high digit scan
  typedef struct packed {
    cnt_t   match_len;   // count of equal low digits of tile and destination
    cnt_t   tile_len;    // significant digits of the tile id
    cnt_t   dest_len;    // significant digits of the destination id
    cnt_t   shared_len;  // significant digits of the shared suffix
    digit_t top_tile;    // highest nonzero tile digit
    digit_t top_dest;    // highest nonzero destination digit
    digit_t mis_dest;    // destination digit at the first mismatch
  } scan_res_t;

  // Step down toward a child
  function automatic port_t port_down(digit_t dig);
    port_t p;
    case (dig)
      4'd1:    p = PORT_NORTH;
      4'd2:    p = PORT_SOUTH;
      4'd3:    p = PORT_WEST;
      4'd4:    p = PORT_EAST;
      default: p = PORT_NONE;
    endcase
    return p;
  endfunction

  // Step up toward the parent
  function automatic port_t port_up(digit_t dig);
    port_t p;
    case (dig)
      4'd1:    p = PORT_SOUTH;
      4'd2:    p = PORT_NORTH;
      4'd3:    p = PORT_EAST;
      4'd4:    p = PORT_WEST;
      default: p = PORT_NONE;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/trnh_if.sv
// Channel interfaces of the next-hop router: destination input, route output
// and configuration write. Depends on trnh_pkg.
`default_nettype none

interface trnh_in_if;
  import trnh_pkg::*;
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] dest_x_tree_id;
  logic [BIN_W-1:0] dest_y_tree_id;
  modport source (output valid, output dest_x_tree_id, output dest_y_tree_id, input ready);
  modport sink   (input valid, input dest_x_tree_id, input dest_y_tree_id, output ready);
endinterface

interface trnh_out_if;
  import trnh_pkg::*;
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] out_port;
  modport source (output valid, output out_port, input ready);
  modport sink   (input valid, input out_port, output ready);
endinterface

interface trnh_cfg_if;
  import trnh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BIN_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/trnh_bin2bcd.sv
// Bit-serial binary to decimal converter (shift and add-3), then a digit
// shifter that hands out the digits low first. Depends on trnh_pkg.
`default_nettype none

module trnh_bin2bcd (
  input  wire                       clk_i,
  input  trnh_pkg::conv_ctl_t       ctl_i,
  input  wire [trnh_pkg::BIN_W-1:0] bin_i,
  output trnh_pkg::digit_t          digit_o
);
  import trnh_pkg::*;

  logic [BIN_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [BCD_W-1:0] bcd_adj;

  // add 3 to every digit of five or more before the next shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (ctl_i.load) begin
      bin_d = bin_i;
      bcd_d = '0;
    end else if (ctl_i.bit_step) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
      bin_d = {bin_q[BIN_W-2:0], 1'b0};
    end else if (ctl_i.digit_step) begin
      bcd_d = {{DIGIT_W{1'b0}}, bcd_q[BCD_W-1:DIGIT_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign digit_o = bcd_q[DIGIT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/trnh_digit_scan.sv
// Digit scan of one tree: with step_i high, takes a tile digit and a destination digit
// per cycle, low first; keeps lengths, match count, key digits. Depends on trnh_pkg.
`default_nettype none

module trnh_digit_scan (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 clear_i,
  input  wire                 step_i,
  input  trnh_pkg::digit_t    tile_digit_i,
  input  trnh_pkg::digit_t    dest_digit_i,
  output trnh_pkg::scan_res_t res_o
);
  import trnh_pkg::*;

  scan_res_t res_q, res_d;
  cnt_t      pos_q, pos_d;
  logic      alive_q, alive_d;
  cnt_t      pos_inc;

  assign pos_inc = pos_q + CNT_W'(1);

  always_comb begin
    res_d   = res_q;
    pos_d   = pos_q;
    alive_d = alive_q;
    if (clear_i) begin
      res_d   = '0;
      pos_d   = '0;
      alive_d = 1'b1;
    end else if (step_i) begin
      pos_d = pos_inc;
      if (tile_digit_i != '0) begin
        res_d.tile_len = pos_inc;
        res_d.top_tile = tile_digit_i;
      end
      if (dest_digit_i != '0) begin
        res_d.dest_len = pos_inc;
        res_d.top_dest = dest_digit_i;
      end
      if (alive_q) begin
        if (tile_digit_i == dest_digit_i) begin
          res_d.match_len = pos_inc;
          if (tile_digit_i != '0) begin
            res_d.shared_len = pos_inc;
          end
        end else begin
          alive_d        = 1'b0;
          res_d.mis_dest = dest_digit_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      alive_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

>>> rtl/tree_route_next_hop_core.sv
// Top level of the two-tree next-hop router: configuration registers, sequencer,
// four decimal converters, two digit scans and the port decision.
// Depends on trnh_pkg, trnh_if, trnh_bin2bcd and trnh_digit_scan.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+------------------------------------------
//   item_i   | in  | valid / ready  | dest_x_tree_id[29:0], dest_y_tree_id[29:0]
//   route_o  | out | valid / ready  | out_port[2:0]
//   cfg_i    | in  | valid / ready  | index[1:0] (0 tile X, 1 tile Y), data[29:0]
//
// One item at a time. After an input transaction the converters shift in the
// four ids one bit a cycle, the scans then walk ID_DIGITS decimal digits low
// first, and the final state loads the result register once it is free; only
// then is a new item taken. Reset clears the tile ids to zero and empties the
// result register. A stalled result holds; the sequencer waits before loading
// a new one, while the tile ids stay writable at all times.
`default_nettype none

module tree_route_next_hop_core #(
  parameter int ID_DIGITS = 9
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  trnh_in_if.sink     item_i,
  trnh_out_if.source  route_o,
  trnh_cfg_if.sink    cfg_i
);
  import trnh_pkg::*;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  cnt_t                 dig_cnt_q, dig_cnt_d;

  logic [BIN_W-1:0] tile_x_q, tile_y_q;

  logic  out_valid_q, out_valid_d;
  port_t out_port_q, out_port_d;

  logic      in_acc;
  logic      res_load;
  conv_ctl_t conv_ctl;

  digit_t    tx_digit, ty_digit, dx_digit, dy_digit;
  scan_res_t res_x, res_y, res_sel;
  logic      use_y;
  cnt_t      down_idx;
  digit_t    down_digit;
  port_t     route_port;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, unknown indexes drop the write
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_x_q <= '0;
      tile_y_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_TILE_X: tile_x_q <= cfg_i.data;
        REG_TILE_Y: tile_y_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign item_i.ready = (state_q == ST_IDLE);
  assign in_acc       = item_i.valid && item_i.ready;

  // in the final state, load the result once the output register is free
  assign res_load = (state_q == ST_FIN) && (!out_valid_q || route_o.ready);

  assign conv_ctl.load       = in_acc;
  assign conv_ctl.bit_step   = (state_q == ST_CONV);
  assign conv_ctl.digit_step = (state_q == ST_SCAN);

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d   = ST_CONV;
          bit_cnt_d = '0;
        end
      end
      ST_CONV: begin
        if (bit_cnt_q == BIT_CNT_W'(BIN_W - 1)) begin
          state_d   = ST_SCAN;
          dig_cnt_d = '0;
        end else begin
          bit_cnt_d = bit_cnt_q + BIT_CNT_W'(1);
        end
      end
      ST_SCAN: begin
        if (dig_cnt_q == CNT_W'(ID_DIGITS - 1)) begin
          state_d = ST_FIN;
        end else begin
          dig_cnt_d = dig_cnt_q + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (res_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      dig_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      dig_cnt_q <= dig_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Decimal converters: tile ids from the registers, destination ids from the
  // input transaction. Only the low ID_DIGITS digits reach the scans, which
  // reduces every id modulo 10^ID_DIGITS.
  // ---------------------------------------------------------------------------
  trnh_bin2bcd u_conv_tx (
    .clk_i   (clk_i),
    .ctl_i   (conv_ctl),
    .bin_i   (tile_x_q),
    .digit_o (tx_digit)
  );

  trnh_bin2bcd u_conv_ty (
    .clk_i   (clk_i),
    .ctl_i   (conv_ctl),
    .bin_i   (tile_y_q),
    .digit_o (ty_digit)
  );

  trnh_bin2bcd u_conv_dx (
    .clk_i   (clk_i),
    .ctl_i   (conv_ctl),
    .bin_i   (item_i.dest_x_tree_id),
    .digit_o (dx_digit)
  );

  trnh_bin2bcd u_conv_dy (
    .clk_i   (clk_i),
    .ctl_i   (conv_ctl),
    .bin_i   (item_i.dest_y_tree_id),
    .digit_o (dy_digit)
  );

  // ---------------------------------------------------------------------------
  // Digit scans, one per tree
  // ---------------------------------------------------------------------------
  trnh_digit_scan u_scan_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (in_acc),
    .step_i       (conv_ctl.digit_step),
    .tile_digit_i (tx_digit),
    .dest_digit_i (dx_digit),
    .res_o        (res_x)
  );

  trnh_digit_scan u_scan_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (in_acc),
    .step_i       (conv_ctl.digit_step),
    .tile_digit_i (ty_digit),
    .dest_digit_i (dy_digit),
    .res_o        (res_y)
  );

  // ---------------------------------------------------------------------------
  // Port decision
  // Work in the Y tree only when its shared suffix has strictly more digits.
  // All digits equal: local. Tile id no longer than the matched low digits
  // means the tile is the shared ancestor: step down by the destination digit
  // at min(match length, top position), unless that lies below the tile's own
  // digits. Otherwise step up by the tile's top digit.
  // ---------------------------------------------------------------------------
  assign use_y   = (res_y.shared_len > res_x.shared_len);
  assign res_sel = use_y ? res_y : res_x;

  // first mismatch below the destination's top digit, or the top digit itself
  assign down_idx   = ((res_sel.match_len + CNT_W'(1)) < res_sel.dest_len) ?
                      res_sel.match_len : (res_sel.dest_len - CNT_W'(1));
  assign down_digit = ((res_sel.match_len + CNT_W'(1)) < res_sel.dest_len) ?
                      res_sel.mis_dest : res_sel.top_dest;

  always_comb begin
    route_port = PORT_NONE;
    if (res_sel.match_len == CNT_W'(ID_DIGITS)) begin
      route_port = PORT_LOCAL;
    end else if (res_sel.tile_len <= res_sel.match_len) begin
      if ((res_sel.dest_len != '0) && (res_sel.tile_len <= down_idx)) begin
        route_port = port_down(down_digit);
      end
    end else begin
      route_port = port_up(res_sel.top_tile);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold while stalled, drop valid once taken
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    out_port_d  = out_port_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_port_d  = route_port;
    end else if (route_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_port_q <= out_port_d;
  end

  assign route_o.valid    = out_valid_q;
  assign route_o.out_port = out_port_q;

endmodule

`default_nettype wire

>>> rtl/trnh_checker.sv
// Port-level checks of the next-hop router, attached to the top level by bind.
// Depends on trnh_pkg and tree_route_next_hop_core.
`default_nettype none

module trnh_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_i,
  input wire                        out_valid_i,
  input wire                        out_ready_i,
  input wire [trnh_pkg::PORT_W-1:0] out_port_i
);
  import trnh_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_port_i))
    else $error("route result changed while stalled");

  // only defined port codes leave the block
  a_port_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_port_i == PORT_LOCAL) || (out_port_i == PORT_NORTH) ||
                    (out_port_i == PORT_SOUTH) || (out_port_i == PORT_EAST) ||
                    (out_port_i == PORT_WEST) || (out_port_i == PORT_NONE))
    else $error("undefined route port code");

  // the block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  // a new result appears only at the end of a busy period
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without work in flight");

endmodule

bind tree_route_next_hop_core trnh_checker u_trnh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (route_o.valid),
  .out_ready_i (route_o.ready),
  .out_port_i  (route_o.out_port)
);

`default_nettype wire

>>> verif/tb_tree_route_next_hop_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for tree_route_next_hop_core: directed and random destination
// pairs under random valid/ready gaps, checked against an in-bench next-hop predictor.
// Depends on trnh_pkg, the trnh_*_if interfaces and the core itself.

module tb_tree_route_next_hop_core;
  import trnh_pkg::*;

  localparam int ID_DIGITS   = 9;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam logic [BIN_W-1:0] ID_ALL_ONES = {BIN_W{1'b1}};
  localparam logic [BIN_W-1:0] ID_DEC_MAX  = 30'd999999999;
  // Indexes beyond the two tile registers; the block must ignore them
  localparam cfg_idx_t REG_SPARE_A = 2'd2;
  localparam cfg_idx_t REG_SPARE_B = 2'd3;

  // Holds the tile ids as written and the ports still owed by the block
  class next_hop_board;
    port_t            pending_ports[$];
    logic [BIN_W-1:0] tile_x;
    logic [BIN_W-1:0] tile_y;
    int               port_mismatches;

    function new();
      tile_x = '0;
      tile_y = '0;
      port_mismatches = 0;
    endfunction

    function longint unsigned pow10(int k);
      longint unsigned p;
      p = 1;
      repeat (k) p = p * 10;
      return p;
    endfunction

    function int digit_len(longint unsigned v);
      int n;
      n = 0;
      while (v > 0 && n < 10) begin
        v = v / 10;
        n++;
      end
      return n;
    endfunction

    // Keep only the low ID_DIGITS decimal digits
    function longint unsigned wrap_id(logic [BIN_W-1:0] v);
      longint unsigned u;
      u = 64'(v);
      return u % pow10(ID_DIGITS > 10 ? 10 : ID_DIGITS);
    endfunction

    // Longest common low-digit run, cut where the tile id runs out of digits
    function longint unsigned shared_suffix(longint unsigned t, longint unsigned d);
      longint unsigned shared;
      shared = 0;
      for (int k = 1; k <= 10 && k <= ID_DIGITS; k++) begin
        if (t % pow10(k) != d % pow10(k) || t / pow10(k - 1) == 0) break;
        shared = t % pow10(k);
      end
      return shared;
    endfunction

    function port_t step_down(longint unsigned dig);
      case (dig)
        1:       return PORT_NORTH;
        2:       return PORT_SOUTH;
        3:       return PORT_WEST;
        4:       return PORT_EAST;
        default: return PORT_NONE;
      endcase
    endfunction

    function port_t step_up(longint unsigned dig);
      case (dig)
        1:       return PORT_SOUTH;
        2:       return PORT_NORTH;
        3:       return PORT_EAST;
        4:       return PORT_WEST;
        default: return PORT_NONE;
      endcase
    endfunction

    function port_t next_hop(longint unsigned tx, longint unsigned ty,
                             longint unsigned dx, longint unsigned dy);
      longint unsigned sx, sy, cur, dst, shr, rest;
      int              len, j, clen;
      bit              use_y;
      sx    = shared_suffix(tx, dx);
      sy    = shared_suffix(ty, dy);
      use_y = digit_len(sy) > digit_len(sx);
      cur   = use_y ? ty : tx;
      dst   = use_y ? dy : dx;
      shr   = use_y ? sy : sx;
      len   = digit_len(dst);
      if (cur == dst) return PORT_LOCAL;
      // Tile is the shared ancestor: step down by the digit above the tile
      if (cur == shr) begin
        j = len;
        while (j > 0) begin
          j--;
          if (dst % pow10(j) == cur) return step_down((dst / pow10(j)) % 10);
        end
        return PORT_NONE;
      end
      // Receive check over the destination's ancestors, then go up
      rest = dst;
      while (rest != shr) begin
        if (len == 0) return PORT_NONE;
        if (rest % pow10(len - 1) == cur) return step_down((rest / pow10(len - 1)) % 10);
        rest = rest % pow10(len - 1);
        len--;
      end
      clen = digit_len(cur);
      if (clen == 0) return PORT_NONE;
      return step_up(cur / pow10(clen - 1));
    endfunction

    function void write_register(cfg_idx_t idx, logic [BIN_W-1:0] data);
      if (idx == REG_TILE_X) tile_x = data;
      else if (idx == REG_TILE_Y) tile_y = data;
    endfunction

    function void note_request(logic [BIN_W-1:0] dx, logic [BIN_W-1:0] dy);
      pending_ports.push_back(next_hop(wrap_id(tile_x), wrap_id(tile_y),
                                       wrap_id(dx), wrap_id(dy)));
    endfunction

    function void check_route(port_t got);
      port_t want;
      if (pending_ports.size() == 0) begin
        $error("out_port: unexpected result, expected none, actual %0d", got);
        port_mismatches++;
        return;
      end
      want = pending_ports.pop_front();
      if (got !== want) begin
        $error("out_port: expected %0d, actual %0d", want, got);
        port_mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycle_cnt = 0;
  bit   calm = 1'b0;          // phase without any idle gaps on either side
  int   stall_left = 0;

  next_hop_board hop_board = new();

  trnh_in_if  item_if ();
  trnh_out_if route_if ();
  trnh_cfg_if cfg_if ();

  tree_route_next_hop_core #(
    .ID_DIGITS(ID_DIGITS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .route_o (route_if),
    .cfg_i   (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Hard stop in case the block hangs or loses a result
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none at all in a calm phase
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly tree digits one to four, sometimes any decimal digit
  function automatic longint unsigned rand_digit();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 4);
    return $urandom_range(0, 9);
  endfunction

  // Add n child steps above the digits of base, never past nine digits
  function automatic longint unsigned grow_id(longint unsigned base, int n);
    longint unsigned p;
    int              len;
    len = hop_board.digit_len(base);
    p   = hop_board.pow10(len);
    for (int i = 0; i < n && len < ID_DIGITS; i++) begin
      base = base + rand_digit() * p;
      p    = p * 10;
      len++;
    end
    return base;
  endfunction

  function automatic logic [BIN_W-1:0] pick_tile();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ID_DEC_MAX;
      2:       return ID_ALL_ONES;
      3:       return BIN_W'($urandom());
      default: return BIN_W'(grow_id(0, $urandom_range(1, ID_DIGITS)));
    endcase
  endfunction

  // Destinations near the tile in its tree, with some unrelated and raw values
  function automatic logic [BIN_W-1:0] pick_dest(longint unsigned t);
    int len;
    len = hop_board.digit_len(t);
    case ($urandom_range(0, 9))
      0:       return BIN_W'(t);
      1, 2:    return BIN_W'(grow_id(t, $urandom_range(1, 3)));
      3:       return BIN_W'(t % hop_board.pow10($urandom_range(0, len)));
      4, 5:    return BIN_W'(grow_id(t % hop_board.pow10($urandom_range(0, len)),
                                     $urandom_range(1, 4)));
      6:       return BIN_W'(grow_id(0, $urandom_range(1, ID_DIGITS)));
      7:       return BIN_W'($urandom());
      8:       return BIN_W'($urandom_range(ID_DEC_MAX, ID_ALL_ONES));
      default: return BIN_W'($urandom_range(0, 99));
    endcase
  endfunction

  // Offer one destination pair and hold it until the block takes it.
  // Valid stays high across back-to-back transactions.
  task automatic send_dest(input logic [BIN_W-1:0] dx, input logic [BIN_W-1:0] dy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid          <= 1'b1;
    item_if.dest_x_tree_id <= dx;
    item_if.dest_y_tree_id <= dy;
    do @(posedge clk_i); while (!item_if.ready);
    hop_board.note_request(dx, dy);
  endtask

  // Drop input valid and wait for every owed result; each item yields one,
  // so the block is idle once the queue is empty
  task automatic drain();
    item_if.valid <= 1'b0;
    while (hop_board.pending_ports.size() != 0) @(posedge clk_i);
  endtask

  // One register transaction; valid is left high for the caller to drop
  task automatic write_reg(input cfg_idx_t idx, input logic [BIN_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    hop_board.write_register(idx, data);
  endtask

  task automatic load_tiles(input logic [BIN_W-1:0] tx, input logic [BIN_W-1:0] ty,
                            input bit spare);
    write_reg(REG_TILE_X, tx);
    write_reg(REG_TILE_Y, ty);
    // A write to an unused index must leave both tile ids alone
    if (spare) write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                         BIN_W'($urandom()));
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: check each transaction, then decide ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && route_if.valid && route_if.ready) hop_board.check_route(route_if.out_port);
    if (stall_left > 0) begin
      stall_left--;
      route_if.ready <= 1'b0;
    end else begin
      route_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    logic [BIN_W-1:0] tx, ty;
    int               random_sent, n;
    item_if.valid          = 1'b0;
    item_if.dest_x_tree_id = '0;
    item_if.dest_y_tree_id = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = REG_TILE_X;
    cfg_if.data            = '0;
    route_if.ready         = 1'b0;
    rst_ni                 = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tile ids at reset: zero tile, digit out of range, root child, wrapped max
    send_dest(0, 0);
    send_dest(5, 7);
    send_dest(1, 0);
    send_dest(ID_ALL_ONES, ID_ALL_ONES);
    drain();

    // Tile 321 in X: local, all four children, ancestors, sibling, bad digit,
    // a zero digit above the tile, and a Y match at the decimal maximum
    load_tiles(321, ID_DEC_MAX, 1'b1);
    send_dest(321, 0);
    send_dest(1321, 0);
    send_dest(2321, 0);
    send_dest(3321, 0);
    send_dest(4321, 0);
    send_dest(21, 0);
    send_dest(421, 0);
    send_dest(5321, 0);
    send_dest(10321, 0);
    send_dest(0, ID_DEC_MAX);
    send_dest(0, ID_ALL_ONES);
    drain();

    // Upward steps by top digits 4, 1, 2 and an out-of-range 5, and Y chosen on a strictly longer suffix
    load_tiles(4, 3, 1'b0);
    send_dest(0, 0);
    send_dest(0, 3);
    send_dest(0, 13);
    drain();
    load_tiles(12, 0, 1'b0);
    send_dest(2, 0);
    drain();
    load_tiles(2, 5, 1'b0);
    send_dest(0, 0);
    drain();
    load_tiles(5, 0, 1'b0);
    send_dest(7, 0);
    drain();

    // Random phases: new tile ids, then destinations mostly near them
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      tx   = pick_tile();
      ty   = pick_tile();
      calm = 1'b0;
      load_tiles(tx, ty, $urandom_range(0, 3) == 0);
      calm = ($urandom_range(0, 3) == 0);
      n    = $urandom_range(30, 90);
      for (int i = 0; i < n; i++) begin
        send_dest(pick_dest(hop_board.wrap_id(tx)), pick_dest(hop_board.wrap_id(ty)));
        random_sent++;
      end
      drain();
    end

    // Let a stray extra result show up before judging
    calm = 1'b0;
    repeat (BIN_W + ID_DIGITS + 10) @(posedge clk_i);
    if (hop_board.port_mismatches == 0 && hop_board.pending_ports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
